### rtl/core/bgh_pkg.sv
// Shared types, register codes and a counter helper for the hybrid branch predictor.
// No dependencies.
package bgh_pkg;

  // Predictor modes; the fourth code behaves as bimodal
  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GSHARE_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_BITS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIMOD_BITS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_BITS = 3'd4;

  localparam int unsigned HIST_W = 16;

  // Counter reset values
  localparam logic [1:0] GSHARE_INIT  = 2'd1;
  localparam logic [1:0] BIMODAL_INIT = 2'd2;
  localparam logic [1:0] CHOOSER_INIT = 2'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] gshare_index_bits;
    logic [4:0] history_bits;
    logic [4:0] bimodal_index_bits;
    logic [4:0] chooser_index_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:               MODE_BIMODAL,
    gshare_index_bits:  5'd10,
    history_bits:       5'd8,
    bimodal_index_bits: 5'd10,
    chooser_index_bits: 5'd8
  };

  typedef struct packed {
    logic [31:0] branch_address;
    logic        taken;
  } branch_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        mispredicted;
    logic [31:0] prediction_total;
    logic [31:0] misprediction_total;
  } result_t;

  // 2-bit saturating counter step
  function automatic logic [1:0] train_ctr(input logic [1:0] c, input logic t);
    logic [1:0] r;
    r = c;
    if (t) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

### rtl/core/bimodal_gshare_hybrid_branch_predictor.sv
// Tournament branch predictor (bimodal + gshare + chooser), top level.
// Depends on bgh_pkg, bgh_index and bgh_ctr_ram.
//
// Takes one resolved branch word per cycle while branch_stall is low and
// returns one result word per branch: the prediction made before training,
// a mispredict flag and saturating branch and miss totals. Sustained rate
// is one branch per clock while result_stall is low. The three counter
// tables are read at the edge a branch is accepted; the modify stage then
// updates the counters, writes them back and loads the result register. A
// branch that hits the entry written by the one just ahead of it takes the
// forwarded value. History is updated at accept time in gshare and hybrid
// modes. After reset a clearing pass sets every counter to its initial
// value; branch_stall is high throughout, while configuration writes are
// taken as ever. cfg_ready is always high. Configuration must only be
// written while the block is idle.
module bimodal_gshare_hybrid_branch_predictor
  import bgh_pkg::*;
#(
  parameter int unsigned GSHARE_INDEX_MAX  = 16,
  parameter int unsigned BIMODAL_INDEX_MAX = 16,
  parameter int unsigned CHOOSER_INDEX_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 branch_valid,
  output logic                 branch_stall,
  input  branch_t              branch,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [4:0]           cfg_data
);

  localparam int unsigned GA = GSHARE_INDEX_MAX;
  localparam int unsigned BA = BIMODAL_INDEX_MAX;
  localparam int unsigned CA = CHOOSER_INDEX_MAX;
  localparam int unsigned GB_MAX = (GA > BA) ? GA : BA;
  localparam int unsigned CLR_AW = (GB_MAX > CA) ? GB_MAX : CA;

  // configuration and history
  cfg_t              cfg;
  logic [HIST_W-1:0] hist;
  logic [HIST_W-1:0] hist_next;

  // clearing pass
  logic              clearing;
  logic [CLR_AW-1:0] clr_cnt;

  // accept-side
  logic          accept;
  logic          adv;
  logic          out_free;
  logic [GA-1:0] gidx;
  logic [BA-1:0] bidx;
  logic [CA-1:0] cidx;

  // modify stage
  logic          s1_valid;
  logic [GA-1:0] s1_gidx;
  logic [BA-1:0] s1_bidx;
  logic [CA-1:0] s1_cidx;
  logic          s1_taken;
  logic [1:0]    s1_mode;

  // last write-back, for forwarding into the next read
  logic          lw_g_we, lw_b_we, lw_c_we;
  logic [GA-1:0] lw_g_addr;
  logic [BA-1:0] lw_b_addr;
  logic [CA-1:0] lw_c_addr;
  logic [1:0]    lw_g_data, lw_b_data, lw_c_data;

  // table ports
  logic [1:0]    g_rdata, b_rdata, c_rdata;
  logic [1:0]    g_cur, b_cur, c_cur;
  logic          g_upd, b_upd, c_upd;
  logic [1:0]    g_new, b_new, c_new;
  logic          g_we, b_we, c_we;
  logic [GA-1:0] g_waddr;
  logic [BA-1:0] b_waddr;
  logic [CA-1:0] c_waddr;
  logic [1:0]    g_wdata, b_wdata, c_wdata;

  logic          pred;
  logic          miss;
  logic [31:0]   branch_count, miss_count;

  assign cfg_ready    = 1'b1;
  // result register can take a new word
  assign out_free     = !result_valid || !result_stall;
  assign adv          = !s1_valid || out_free;
  assign branch_stall = clearing || !adv;
  assign accept       = branch_valid && !branch_stall;

  bgh_index #(
    .GMAX (GA),
    .BMAX (BA),
    .CMAX (CA)
  ) u_index (
    .cfg       (cfg),
    .word      (branch.branch_address[31:2]),
    .hist      (hist),
    .taken     (branch.taken),
    .gidx      (gidx),
    .bidx      (bidx),
    .cidx      (cidx),
    .hist_next (hist_next)
  );

  // Forward the write that landed on the same edge as our read
  always_comb begin
    g_cur = (lw_g_we && lw_g_addr == s1_gidx) ? lw_g_data : g_rdata;
    b_cur = (lw_b_we && lw_b_addr == s1_bidx) ? lw_b_data : b_rdata;
    c_cur = (lw_c_we && lw_c_addr == s1_cidx) ? lw_c_data : c_rdata;
  end

  // Prediction and training
  always_comb begin
    g_upd = 1'b0;
    b_upd = 1'b0;
    c_upd = 1'b0;
    case (s1_mode)
      MODE_GSHARE: begin
        pred  = g_cur[1];
        g_upd = 1'b1;
      end
      MODE_HYBRID: begin
        if (c_cur[1]) begin
          pred  = g_cur[1];
          g_upd = 1'b1;
        end else begin
          pred  = b_cur[1];
          b_upd = 1'b1;
        end
        // chooser only moves when the two disagree
        c_upd = (g_cur[1] != b_cur[1]);
      end
      default: begin
        pred  = b_cur[1];
        b_upd = 1'b1;
      end
    endcase
    g_new = train_ctr(g_cur, s1_taken);
    b_new = train_ctr(b_cur, s1_taken);
    c_new = train_ctr(c_cur, g_cur[1] == s1_taken);
    miss  = (pred != s1_taken);
  end

  // Write port: clearing sweep, else write-back from the modify stage
  always_comb begin
    if (clearing) begin
      g_we    = 1'b1;
      b_we    = 1'b1;
      c_we    = 1'b1;
      g_waddr = clr_cnt[GA-1:0];
      b_waddr = clr_cnt[BA-1:0];
      c_waddr = clr_cnt[CA-1:0];
      g_wdata = GSHARE_INIT;
      b_wdata = BIMODAL_INIT;
      c_wdata = CHOOSER_INIT;
    end else begin
      g_we    = adv && s1_valid && g_upd;
      b_we    = adv && s1_valid && b_upd;
      c_we    = adv && s1_valid && c_upd;
      g_waddr = s1_gidx;
      b_waddr = s1_bidx;
      c_waddr = s1_cidx;
      g_wdata = g_new;
      b_wdata = b_new;
      c_wdata = c_new;
    end
  end

  bgh_ctr_ram #(.AW(GA)) u_gshare_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (accept),
    .raddr (gidx),
    .rdata (g_rdata)
  );

  bgh_ctr_ram #(.AW(BA)) u_bimodal_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (accept),
    .raddr (bidx),
    .rdata (b_rdata)
  );

  bgh_ctr_ram #(.AW(CA)) u_chooser_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (accept),
    .raddr (cidx),
    .rdata (c_rdata)
  );

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:        cfg.mode               <= cfg_data[1:0];
        CFG_GSHARE_BITS: cfg.gshare_index_bits  <= cfg_data;
        CFG_HIST_BITS:   cfg.history_bits       <= cfg_data;
        CFG_BIMOD_BITS:  cfg.bimodal_index_bits <= cfg_data;
        CFG_CHOOSE_BITS: cfg.chooser_index_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (&clr_cnt) begin
        clearing <= 1'b0;
      end
    end
  end

  // Global history moves at accept in the modes that use it
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (accept && (cfg.mode == MODE_GSHARE || cfg.mode == MODE_HYBRID)) begin
      hist <= hist_next;
    end
  end

  // Modify stage and last-write record
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lw_g_we  <= 1'b0;
      lw_b_we  <= 1'b0;
      lw_c_we  <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      lw_g_we  <= s1_valid && g_upd;
      lw_b_we  <= s1_valid && b_upd;
      lw_c_we  <= s1_valid && c_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gidx  <= gidx;
      s1_bidx  <= bidx;
      s1_cidx  <= cidx;
      s1_taken <= branch.taken;
      s1_mode  <= cfg.mode;
    end
    if (adv) begin
      lw_g_addr <= s1_gidx;
      lw_b_addr <= s1_bidx;
      lw_c_addr <= s1_cidx;
      lw_g_data <= g_new;
      lw_b_data <= b_new;
      lw_c_data <= c_new;
    end
  end

  // Running totals and result register; a stalled result word stays put
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      branch_count <= '0;
      miss_count   <= '0;
    end else if (out_free) begin
      result_valid <= s1_valid;
      if (s1_valid) begin
        if (branch_count != '1) branch_count <= branch_count + 32'd1;
        if (miss && miss_count != '1) miss_count <= miss_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      result.predicted_taken     <= pred;
      result.mispredicted        <= miss;
      result.prediction_total    <= (branch_count != '1) ? branch_count + 32'd1 : branch_count;
      result.misprediction_total <= (miss && miss_count != '1) ? miss_count + 32'd1
                                                                : miss_count;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> branch_stall)
    else $error("branch accepted during clearing pass");

  a_miss_total_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.misprediction_total <= result.prediction_total))
    else $error("miss total exceeds branch total");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_gidx) && $stable(s1_taken)))
    else $error("modify stage lost its word under stall");

  a_no_write_when_held: assert property (@(posedge clk) disable iff (rst)
    (!clearing && !adv) |-> !(g_we || b_we || c_we))
    else $error("table written while modify stage held");
`endif

endmodule

### rtl/core/bgh_ctr_ram.sv
// Counter table: single write port, single registered read port, 2-bit words.
// Depends on nothing.
module bgh_ctr_ram #(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata
);

  logic [1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bgh_index.sv
// Table index generation and global history shift for the hybrid predictor.
// Depends on bgh_pkg.
module bgh_index
  import bgh_pkg::*;
#(
  parameter int unsigned GMAX = 16,
  parameter int unsigned BMAX = 16,
  parameter int unsigned CMAX = 16
) (
  input  cfg_t              cfg,
  input  logic [29:0]       word,
  input  logic [HIST_W-1:0] hist,
  input  logic              taken,
  output logic [GMAX-1:0]   gidx,
  output logic [BMAX-1:0]   bidx,
  output logic [CMAX-1:0]   cidx,
  output logic [HIST_W-1:0] hist_next
);

  logic [4:0]        gm, bm, cm, hn, hn_g, sh;
  logic [HIST_W:0]   hmask_w, tbit_w;
  logic [HIST_W-1:0] hmask, hist_m;
  logic [GMAX:0]     gmask_w;
  logic [BMAX:0]     bmask_w;
  logic [CMAX:0]     cmask_w;
  logic [47:0]       hx, gw;

  always_comb begin
    // clamp widths to table sizes
    gm = (cfg.gshare_index_bits  > 5'(GMAX)) ? 5'(GMAX) : cfg.gshare_index_bits;
    bm = (cfg.bimodal_index_bits > 5'(BMAX)) ? 5'(BMAX) : cfg.bimodal_index_bits;
    cm = (cfg.chooser_index_bits > 5'(CMAX)) ? 5'(CMAX) : cfg.chooser_index_bits;
    hn_g = (cfg.history_bits > gm) ? gm : cfg.history_bits;
    hn   = (hn_g > 5'(HIST_W)) ? 5'(HIST_W) : hn_g;
    sh   = gm - hn;

    hmask_w = ((HIST_W+1)'(1) << hn) - (HIST_W+1)'(1);
    hmask   = hmask_w[HIST_W-1:0];
    hist_m  = hist & hmask;

    gmask_w = ((GMAX+1)'(1) << gm) - (GMAX+1)'(1);
    bmask_w = ((BMAX+1)'(1) << bm) - (BMAX+1)'(1);
    cmask_w = ((CMAX+1)'(1) << cm) - (CMAX+1)'(1);

    hx   = 48'(hist_m) << sh;
    gw   = 48'(word) ^ hx;
    gidx = gw[GMAX-1:0] & gmask_w[GMAX-1:0];
    bidx = word[BMAX-1:0] & bmask_w[BMAX-1:0];
    cidx = word[CMAX-1:0] & cmask_w[CMAX-1:0];

    // outcome enters at bit hn-1; nothing enters when hn is zero
    tbit_w    = ((HIST_W+1)'(taken) << hn) >> 1;
    hist_next = ((hist_m >> 1) | tbit_w[HIST_W-1:0]) & hmask;
  end

endmodule

### tb/bimodal_gshare_hybrid_branch_predictor_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the tournament branch predictor top level.
// Uses bgh_pkg types and register codes; needs only the predictor RTL.
module bimodal_gshare_hybrid_branch_predictor_test;
  import bgh_pkg::*;

  // The fourth mode code has no name in the package; it must act as bimodal
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int TABLE_DEPTH  = 65536;
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int DRAIN_CYCLES = 6;        // settle time after the last result word
  localparam int PHASE_WORDS  = 40;
  localparam int POOL_SIZE    = 8;
  localparam longint CYCLE_LIMIT = 1000000;

  // Outcome patterns for the hot branches of a phase
  typedef enum int {
    ALWAYS_TAKEN, NEVER_TAKEN, ALTERNATING, TWO_IN_THREE, MOSTLY_TAKEN
  } branch_habit_e;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 branch_valid = 1'b0;
  logic                 branch_stall;
  branch_t              branch       = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_MODE;
  logic [4:0]           cfg_data     = '0;

  bimodal_gshare_hybrid_branch_predictor dut (
    .clk          (clk),
    .rst          (rst),
    .branch_valid (branch_valid),
    .branch_stall (branch_stall),
    .branch       (branch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // In-bench copy of the predictor state
  // ---------------------------------------------------------------------------
  cfg_t        model_cfg;
  logic [1:0]  gshare_ctr  [TABLE_DEPTH];
  logic [1:0]  bimodal_ctr [TABLE_DEPTH];
  logic [1:0]  chooser_ctr [TABLE_DEPTH];
  logic [15:0] model_history;
  logic [31:0] model_branches;
  logic [31:0] model_misses;

  branch_t pending_branches [$];   // words waiting for the driver
  result_t expected_results [$];   // predictions awaiting their result word

  int     send_gap       = 0;
  int     recv_gap       = 0;
  int     hold_left      = 0;
  int     hold_requests  = 0;
  int     hold_served    = 0;
  int     mismatch_count = 0;
  longint cycle_count    = 0;
  bit     send_idle_on   = 1'b1;
  bit     recv_idle_on   = 1'b1;
  bit     branch_accepted = 1'b0;

  function automatic logic [31:0] width_mask(int bits);
    return (32'h1 << bits) - 32'h1;
  endfunction

  // Index widths above the table size fall back to the table size (16)
  function automatic int clamp16(logic [4:0] bits);
    return (bits > 5'd16) ? 16 : int'(bits);
  endfunction

  function automatic logic [1:0] bump(logic [1:0] c, logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic reset_model();
    model_cfg = CFG_RESET;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      gshare_ctr[i]  = GSHARE_INIT;
      bimodal_ctr[i] = BIMODAL_INIT;
      chooser_ctr[i] = CHOOSER_INIT;
    end
    model_history  = '0;
    model_branches = '0;
    model_misses   = '0;
  endtask

  // Predicts one resolved branch, trains the copied tables and returns the
  // result word the block should give for it.
  function automatic result_t predict_branch(branch_t b);
    logic [31:0] word_addr;
    logic [31:0] hist;
    logic [31:0] next_hist;
    logic [31:0] gidx;
    logic [31:0] bidx;
    logic [31:0] cidx;
    int          gm;
    int          n;
    int          bm;
    int          cm;
    logic        gpred;
    logic        bpred;
    logic        pred;
    logic        use_history;
    result_t     r;
    word_addr = b.branch_address >> 2;
    gm = clamp16(model_cfg.gshare_index_bits);
    n  = clamp16(model_cfg.history_bits);
    if (n > gm) n = gm;              // history never longer than the gshare index
    bm = clamp16(model_cfg.bimodal_index_bits);
    cm = clamp16(model_cfg.chooser_index_bits);

    hist = {16'h0, model_history} & width_mask(n);
    gidx = (word_addr ^ (hist << (gm - n))) & width_mask(gm);
    bidx = word_addr & width_mask(bm);
    cidx = word_addr & width_mask(cm);

    gpred = gshare_ctr[gidx[15:0]] >= 2'd2;
    bpred = bimodal_ctr[bidx[15:0]] >= 2'd2;
    pred  = bpred;
    use_history = 1'b1;

    case (model_cfg.mode)
      MODE_GSHARE: begin
        pred = gpred;
        gshare_ctr[gidx[15:0]] = bump(gshare_ctr[gidx[15:0]], b.taken);
      end
      MODE_HYBRID: begin
        if (chooser_ctr[cidx[15:0]] >= 2'd2) begin
          pred = gpred;
          gshare_ctr[gidx[15:0]] = bump(gshare_ctr[gidx[15:0]], b.taken);
        end else begin
          pred = bpred;
          bimodal_ctr[bidx[15:0]] = bump(bimodal_ctr[bidx[15:0]], b.taken);
        end
        // chooser only moves when the two sides disagree
        if (gpred != bpred)
          chooser_ctr[cidx[15:0]] = bump(chooser_ctr[cidx[15:0]], gpred == b.taken);
      end
      default: begin   // bimodal, and the unused code
        pred = bpred;
        bimodal_ctr[bidx[15:0]] = bump(bimodal_ctr[bidx[15:0]], b.taken);
        use_history = 1'b0;
      end
    endcase

    if (use_history) begin
      next_hist = hist >> 1;
      if (b.taken && n > 0) next_hist = next_hist | (32'h1 << (n - 1));
      model_history = 16'(next_hist & width_mask(n));
    end

    model_branches = sat_inc(model_branches);
    if (pred != b.taken) model_misses = sat_inc(model_misses);

    r.predicted_taken     = pred;
    r.mispredicted        = pred != b.taken;
    r.prediction_total    = model_branches;
    r.misprediction_total = model_misses;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued branch words, holds a stalled word steady
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (branch_valid && !branch_accepted) begin
      // stalled: keep valid and payload as they are
    end else if (send_gap != 0) begin
      branch_valid <= 1'b0;
      send_gap     <= send_gap - 1;
    end else if (pending_branches.size() != 0) begin
      branch       <= pending_branches.pop_front();
      branch_valid <= 1'b1;
      send_gap     <= send_idle_on ? pick_gap() : 0;
    end else begin
      branch_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served  <= hold_served + 1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap     <= recv_gap - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      recv_gap     <= recv_idle_on ? pick_gap() : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result word against the oldest prediction, then
  // predicts the branch word taken at this edge (its result word is
  // registered, so the check never needs this edge's prediction).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", result);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.predicted_taken !== want.predicted_taken) begin
          $error("predicted_taken: expected %0d, got %0d",
                 want.predicted_taken, result.predicted_taken);
          mismatch_count++;
        end
        if (result.mispredicted !== want.mispredicted) begin
          $error("mispredicted: expected %0d, got %0d",
                 want.mispredicted, result.mispredicted);
          mismatch_count++;
        end
        if (result.prediction_total !== want.prediction_total) begin
          $error("prediction_total: expected %0d, got %0d",
                 want.prediction_total, result.prediction_total);
          mismatch_count++;
        end
        if (result.misprediction_total !== want.misprediction_total) begin
          $error("misprediction_total: expected %0d, got %0d",
                 want.misprediction_total, result.misprediction_total);
          mismatch_count++;
        end
      end
    end
    branch_accepted = !rst && branch_valid && !branch_stall;
    if (branch_accepted) expected_results.push_back(predict_branch(branch));
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_branch(logic [31:0] addr, logic t);
    branch_t b;
    b.branch_address = addr;
    b.taken          = t;
    pending_branches.push_back(b);
  endfunction

  // One register write; the copied settings follow at the accepting edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:        model_cfg.mode               = value[1:0];
      CFG_GSHARE_BITS: model_cfg.gshare_index_bits  = value;
      CFG_HIST_BITS:   model_cfg.history_bits       = value;
      CFG_BIMOD_BITS:  model_cfg.bimodal_index_bits = value;
      CFG_CHOOSE_BITS: model_cfg.chooser_index_bits = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(logic [4:0] mode_data, logic [4:0] gbits, logic [4:0] hbits,
                              logic [4:0] bbits, logic [4:0] cbits);
    write_reg(CFG_MODE, mode_data);
    write_reg(CFG_GSHARE_BITS, gbits);
    write_reg(CFG_HIST_BITS, hbits);
    write_reg(CFG_BIMOD_BITS, bbits);
    write_reg(CFG_CHOOSE_BITS, cbits);
  endtask

  // Block is idle once every word is sent and every result is back
  task automatic wait_idle();
    while (pending_branches.size() != 0 || branch_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A phase of branch words: a small pool of hot branches with fixed habits,
  // visited partly in loop order so history has something to learn, plus
  // some noise words at random addresses.
  task automatic queue_phase(int words);
    logic [31:0]   pool_addr [POOL_SIZE];
    branch_habit_e pool_habit [POOL_SIZE];
    int            pool_step [POOL_SIZE];
    int            k;
    logic          t;
    for (int i = 0; i < POOL_SIZE; i++) begin
      // some pool entries alias the first one in the smaller tables
      if (i > 0 && $urandom_range(0, 3) == 0)
        pool_addr[i] = pool_addr[0] ^ (32'h1 << $urandom_range(10, 31));
      else
        pool_addr[i] = $urandom();
      pool_habit[i] = branch_habit_e'($urandom_range(0, 4));
      pool_step[i]  = 0;
    end
    for (int w = 0; w < words; w++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_branch($urandom(), 1'($urandom_range(0, 1)));
      end else begin
        k = $urandom_range(0, 1) ? (w % POOL_SIZE) : $urandom_range(0, POOL_SIZE - 1);
        case (pool_habit[k])
          ALWAYS_TAKEN: t = 1'b1;
          NEVER_TAKEN:  t = 1'b0;
          ALTERNATING:  t = pool_step[k][0];
          TWO_IN_THREE: t = (pool_step[k] % 3) != 2;
          default:      t = $urandom_range(0, 9) != 0;
        endcase
        pool_step[k]++;
        push_branch(pool_addr[k], t);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings (bimodal): address extremes, saturate a counter both ways
    push_branch(32'h0000_0000, 1'b0);
    push_branch(32'h0000_0000, 1'b0);
    push_branch(32'h0000_0000, 1'b0);
    push_branch(32'h0000_0003, 1'b1);   // same entry, low two bits ignored
    push_branch(32'hFFFF_FFFF, 1'b1);
    push_branch(32'hFFFF_FFFF, 1'b1);
    push_branch(32'hFFFF_FFFF, 1'b0);
    push_branch(32'h0000_0FFC, 1'b1);   // top entry of a 10-bit table
    wait_idle();

    // gshare: history folds into the index as outcomes arrive
    write_reg(CFG_MODE, 5'(MODE_GSHARE));
    push_branch(32'h0000_0100, 1'b1);
    push_branch(32'h0000_0100, 1'b1);
    push_branch(32'h0000_0100, 1'b1);
    push_branch(32'h0000_0100, 1'b1);
    push_branch(32'h0000_0100, 1'b0);
    push_branch(32'hFFFF_FFFC, 1'b1);
    wait_idle();

    // hybrid: disagreements move the chooser
    write_reg(CFG_MODE, 5'(MODE_HYBRID));
    push_branch(32'h0000_0040, 1'b1);
    push_branch(32'h0000_0040, 1'b1);
    push_branch(32'h0000_0040, 1'b1);
    push_branch(32'h0000_0040, 1'b1);
    push_branch(32'h0000_0040, 1'b0);
    push_branch(32'h0000_0040, 1'b1);
    wait_idle();

    // unused mode code, written with the spare data bits set
    write_reg(CFG_MODE, {3'b111, MODE_UNUSED});
    push_branch(32'h0000_0040, 1'b0);
    push_branch(32'h8000_0000, 1'b1);
    wait_idle();

    // zero widths everywhere: single-entry tables, no history
    load_setting(5'(MODE_HYBRID), 5'd0, 5'd0, 5'd0, 5'd0);
    push_branch(32'h1234_5678, 1'b1);
    push_branch(32'hEDCB_A987, 1'b0);
    wait_idle();

    // Random phases: fixed extremes first, then random settings
    for (int p = 0; p < 10; p++) begin
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      case (p)
        0: load_setting(5'(MODE_HYBRID), 5'd16, 5'd16, 5'd16, 5'd16);
        1: load_setting(5'(MODE_HYBRID), 5'd31, 5'd31, 5'd31, 5'd31);   // all clamped
        2: begin
          // long history cut to a short gshare index; receiver holds off
          // while the sender keeps offering, so the block backs up
          load_setting(5'(MODE_GSHARE), 5'd4, 5'd31, 5'd2, 5'd1);
          send_idle_on = 1'b0;
          hold_requests++;
        end
        3: load_setting(5'(MODE_GSHARE), 5'd12, 5'd0, 5'd10, 5'd8);
        4: load_setting(5'(MODE_HYBRID), 5'd1, 5'd1, 5'd1, 5'd1);
        default: load_setting({3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))},
                              5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                              5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      endcase
      queue_phase(PHASE_WORDS);
      wait_idle();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
